@@ design/assert_macros.svh @@
// Assertion macros for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, cond, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ design/lfbt_pkg.sv @@
package lfbt_pkg;
    localparam logic [1:0] REQ_QUERY   = 2'd0;
    localparam logic [1:0] REQ_FAILURE = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic [1:0] CFG_MAX_FAILURES = 2'd0;
    localparam logic [1:0] CFG_WINDOW_TICKS = 2'd1;
    localparam logic [1:0] CFG_BAN_TICKS    = 2'd2;

    // Depth of each stamp ring; the ring wraps by bit width, so it stays a power of two.
    localparam int MAX_FAILURE_LIMIT = 16;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
        logic        is_ipv6;
        logic        fast;
        logic        fast_banned;
    } t_cmd;

    typedef struct packed {
        logic banned;
        logic newly_banned;
        logic table_full;
    } t_result;
endpackage

@@ design/lfbt_front.sv @@
// Front end: masks the key and settles the requests that need no table access.
module lfbt_front import lfbt_pkg::*; (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_address,
    input  logic        i_is_ipv6,
    input  logic        i_address_valid,
    input  logic        i_lim_zero,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_full
);
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Requests that are answered without the table skip the search.
    always_comb begin
        o_cmd.req_type    = i_req_type;
        o_cmd.is_ipv6     = i_is_ipv6;
        o_cmd.key         = i_is_ipv6 ? i_address : {32'd0, i_address[31:0]};
        o_cmd.fast        = 1'b0;
        o_cmd.fast_banned = 1'b0;
        if (i_req_type != REQ_TICK) begin
            if (i_req_type == REQ_UNUSED || i_lim_zero) begin
                o_cmd.fast = 1'b1;
            end else if (!i_address_valid) begin
                o_cmd.fast        = 1'b1;
                o_cmd.fast_banned = 1'b1;
            end
        end
    end
endmodule

@@ design/lfbt_queue.sv @@
// Two-entry queue between the front and back ends.
module lfbt_queue import lfbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

@@ design/lfbt_back.sv @@
// Back end: scans the table one entry a cycle and updates the record.
module lfbt_back import lfbt_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  logic [$clog2(MAX_FAILURE_LIMIT+1)-1:0] i_lim,
    input  logic [31:0] i_window,
    input  logic [31:0] i_ban,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_res,
    output logic        o_busy
);
    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam int RW = (MAX_FAILURE_LIMIT > 1) ? $clog2(MAX_FAILURE_LIMIT) : 1;
    localparam int CW = $clog2(MAX_FAILURE_LIMIT + 1);
    localparam int SD = TABLE_ENTRIES * MAX_FAILURE_LIMIT;
    localparam int SW = $clog2(SD);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_OLD   = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [63:0] m_key  [TABLE_ENTRIES];
    logic        m_v6   [TABLE_ENTRIES];
    logic [CW-1:0] m_cnt [TABLE_ENTRIES];
    logic [RW-1:0] m_head [TABLE_ENTRIES];
    logic [31:0] m_dl   [TABLE_ENTRIES];
    logic [31:0] m_ring [SD];

    t_state      r_state;
    logic [EW:0] r_idx;
    logic [EW-1:0] r_hit, r_free;
    logic        r_found, r_have_free;
    logic [31:0] r_now;
    logic [63:0] r_rkey;
    logic        r_rv6;
    logic [CW-1:0] r_rcnt;
    logic [RW-1:0] r_rhead;
    logic [31:0] r_rdl;
    logic [31:0] r_old;
    t_result     r_res;
    logic [EW-1:0] w_e;
    logic [RW-1:0] w_slot;
    logic [CW-1:0] w_cnt1;
    logic        w_append;

    assign o_valid = r_state == S_OUT;
    assign o_res   = r_res;
    // The command stays at the queue head until its result is taken.
    assign o_pop   = r_state == S_OUT && i_ready;
    assign o_busy  = r_state != S_IDLE || !i_empty;
    assign w_e     = r_found ? r_hit : r_free;
    assign w_slot  = RW'(r_rhead + RW'(r_rcnt));
    assign w_cnt1  = r_rcnt + CW'(1);
    // Only a failure on a record below the limit appends a stamp.
    assign w_append = i_cmd.req_type != REQ_QUERY && !(r_found && r_rcnt >= i_lim);

    // Registered reads of the current scan entry and of the oldest stamp.
    always_ff @(posedge i_clk) begin
        r_rkey  <= m_key[r_idx[EW-1:0]];
        r_rv6   <= m_v6[r_idx[EW-1:0]];
        r_rdl   <= m_dl[r_idx[EW-1:0]];
        r_old   <= m_ring[SW'({w_e, r_rhead})];
        if (r_state == S_RD) begin
            r_rcnt  <= r_found ? m_cnt[w_e] : '0;
            r_rhead <= r_found ? m_head[w_e] : '0;
        end
        // Record update writes.
        if (r_state == S_WRITE && w_append) begin
            m_ring[SW'({w_e, w_slot})] <= r_now;
            if (!r_found) begin
                m_key[w_e] <= i_cmd.key;
                m_v6[w_e]  <= i_cmd.is_ipv6;
            end
        end
        if (r_state == S_DONE) begin
            if (w_cnt1 >= i_lim && r_now - r_old <= i_window) begin
                m_cnt[w_e] <= w_cnt1;
                m_head[w_e] <= r_rhead;
                m_dl[w_e]  <= r_now + i_ban;
            end else if (w_cnt1 >= i_lim) begin
                m_cnt[w_e] <= r_rcnt;
                m_head[w_e] <= RW'(r_rhead + RW'(1));
                m_dl[w_e]  <= r_now + i_window;
            end else begin
                m_cnt[w_e] <= w_cnt1;
                m_head[w_e] <= r_rhead;
                m_dl[w_e]  <= r_now + i_window;
            end
        end
    end

    // Sequencer; each scan step compares the entry read in the prior cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_now   <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_have_free <= 1'b0;
            r_hit   <= '0;
            r_free  <= '0;
            r_res   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_have_free <= 1'b0;
                        if (i_cmd.fast) begin
                            r_res <= '{banned: i_cmd.fast_banned, newly_banned: 1'b0,
                                       table_full: 1'b0};
                            r_state <= S_OUT;
                        end else begin
                            r_res <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + (EW+1)'(1);
                    if (r_idx != '0) begin
                        if (r_valid[r_idx[EW-1:0] - 1'b1]) begin
                            if (i_cmd.req_type == REQ_TICK) begin
                                if (r_rdl == r_now) begin
                                    r_valid[r_idx[EW-1:0] - 1'b1] <= 1'b0;
                                end
                            end else if (!r_found && r_rkey == i_cmd.key
                                         && r_rv6 == i_cmd.is_ipv6) begin
                                r_found <= 1'b1;
                                r_hit   <= r_idx[EW-1:0] - 1'b1;
                            end
                        end else if (!r_have_free) begin
                            r_have_free <= 1'b1;
                            r_free <= r_idx[EW-1:0] - 1'b1;
                        end
                    end
                    if (r_idx == (EW+1)'(TABLE_ENTRIES)) begin
                        if (i_cmd.req_type == REQ_TICK) begin
                            r_now <= r_now + 32'd1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (i_cmd.req_type == REQ_QUERY) begin
                        r_state <= S_WRITE;
                    end else if (!r_found && !r_have_free) begin
                        r_res.table_full <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (i_cmd.req_type == REQ_QUERY) begin
                        r_res.banned <= r_found && r_rcnt >= i_lim;
                        r_state <= S_OUT;
                    end else if (r_found && r_rcnt >= i_lim) begin
                        r_res.banned <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_valid[w_e] <= 1'b1;
                        r_state <= S_OLD;
                    end
                end
                S_OLD: r_state <= S_DONE;
                S_DONE: begin
                    if (w_cnt1 >= i_lim && r_now - r_old <= i_window) begin
                        r_res <= '{banned: 1'b1, newly_banned: 1'b1, table_full: 1'b0};
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/login_failure_ban_table_unit.sv @@
// Login failure ban table. Requests enter on the slave stream and each gives
// one result on the master stream. A front end classifies requests into a
// two-entry queue; the back end walks the whole table one entry per cycle.
// Requests with banning disabled, an invalid address or an unused type skip
// the table scan. Stalls on the master stream hold the result. Configuration
// is written through its own valid/ready channel; the user must write it only
// while the block is idle, which the block itself does not enforce.
`include "assert_macros.svh"
module login_failure_ban_table_unit import lfbt_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: address[63:0], is_ipv6[64], address_valid[65], zero fill
    input  logic [71:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: banned[0], newly_banned[1], table_full[2], zero fill
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int CW = $clog2(MAX_FAILURE_LIMIT + 1);

    logic [4:0]  r_max;
    logic [31:0] r_window, r_ban;
    logic [CW-1:0] w_lim;
    logic        w_push, w_full, w_pop, w_empty, w_busy;
    logic        w_out_new, w_out_full, w_out_stall;
    t_cmd        w_cmd_in, w_cmd_out;
    t_result     w_res;

    assign o_cfg_ready = 1'b1;
    assign w_lim = (32'(r_max) > MAX_FAILURE_LIMIT) ? CW'(MAX_FAILURE_LIMIT) : CW'(r_max);
    assign m_axis_tdata = {5'd0, w_res.table_full, w_res.newly_banned, w_res.banned};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= 5'd0;
            r_window <= 32'd100;
            r_ban    <= 32'd1000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_FAILURES: r_max    <= i_cfg_data[4:0];
                CFG_WINDOW_TICKS: r_window <= i_cfg_data;
                CFG_BAN_TICKS:    r_ban    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lfbt_front u_front (
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req_type(s_axis_tuser), .i_address(s_axis_tdata[63:0]),
        .i_is_ipv6(s_axis_tdata[64]), .i_address_valid(s_axis_tdata[65]),
        .i_lim_zero(w_lim == '0),
        .o_push(w_push), .o_cmd(w_cmd_in), .i_full(w_full)
    );

    lfbt_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_cmd(w_cmd_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_cmd(w_cmd_out)
    );

    lfbt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk, .i_rst_n,
        .i_empty(w_empty), .i_cmd(w_cmd_out), .o_pop(w_pop),
        .i_lim(w_lim), .i_window(r_window), .i_ban(r_ban),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res), .o_busy(w_busy)
    );

    // Result flags seen by the checks below.
    assign w_out_new   = m_axis_tvalid && w_res.newly_banned;
    assign w_out_full  = m_axis_tvalid && w_res.table_full;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    `ASSERT_IMPL(a_new_ban, i_clk, i_rst_n, !w_out_new || w_res.banned, "new ban without banned")
    `ASSERT_IMPL(a_full_excl, i_clk, i_rst_n, !(w_out_full && w_res.banned), "full and banned")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid && w_busy, "result lost")
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import lfbt_pkg::*; ();

    localparam int SLOTS       = 64;
    localparam int STAMP_DEPTH = 16;
    localparam int SETTLE      = 120;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PEND_DEPTH  = 4096;
    localparam int DIR_DEPTH   = 32;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    login_failure_ban_table_unit dut (.*);

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the ban table and its settings.
    logic [4:0]  lim_reg;
    logic [31:0] window_reg;
    logic [31:0] ban_len_reg;
    logic        rec_used   [SLOTS];
    logic [63:0] rec_key    [SLOTS];
    logic        rec_v6     [SLOTS];
    logic [4:0]  rec_count  [SLOTS];
    logic [3:0]  rec_head   [SLOTS];
    logic [31:0] rec_expiry [SLOTS];
    logic [31:0] rec_stamp  [SLOTS][STAMP_DEPTH];
    logic [31:0] now_reg;

    // Expected {table_full, newly_banned, banned} per pending result.
    logic [2:0] pending_verdicts [PEND_DEPTH];
    int         pend_wr = 0;
    int         pend_rd = 0;
    int         error_count = 0;
    int         verdicts_seen = 0;
    int         new_bans_seen = 0;
    int         full_seen = 0;
    int         idle_cycles = 0;

    // Applies one request to the shadow table and returns its verdict.
    function automatic logic [2:0] ban_verdict(logic [1:0] req, logic [63:0] addr,
                                               logic v6, logic ok);
        logic [63:0] key;
        logic [4:0]  lim;
        logic [3:0]  slot;
        int          hit;
        key = v6 ? addr : {32'd0, addr[31:0]};
        lim = (lim_reg > STAMP_DEPTH) ? 5'(STAMP_DEPTH) : lim_reg;
        hit = -1;
        if (req == REQ_TICK) begin
            for (int i = 0; i < SLOTS; i++)
                if (rec_used[i] && rec_expiry[i] == now_reg)
                    rec_used[i] = 1'b0;
            now_reg = now_reg + 32'd1;
            return 3'b000;
        end
        if (req != REQ_QUERY && req != REQ_FAILURE) return 3'b000;
        if (lim == 0) return 3'b000;
        if (!ok) return 3'b001;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && rec_used[i] && rec_key[i] == key && rec_v6[i] == v6)
                hit = i;
        if (req == REQ_QUERY)
            return (hit >= 0 && rec_count[hit] >= lim) ? 3'b001 : 3'b000;
        // A failure on an unknown address takes the lowest free record.
        if (hit < 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && !rec_used[i]) begin
                    hit = i;
                    rec_used[i]   = 1'b1;
                    rec_key[i]    = key;
                    rec_v6[i]     = v6;
                    rec_count[i]  = 5'd0;
                    rec_head[i]   = 4'd0;
                    rec_expiry[i] = now_reg;
                end
            if (hit < 0) return 3'b100;
        end
        if (rec_count[hit] >= lim) return 3'b001;
        slot = rec_head[hit] + 4'(rec_count[hit]);
        rec_stamp[hit][slot] = now_reg;
        rec_count[hit] = rec_count[hit] + 5'd1;
        if (rec_count[hit] >= lim) begin
            if (now_reg - rec_stamp[hit][rec_head[hit]] <= window_reg) begin
                rec_expiry[hit] = now_reg + ban_len_reg;
                return 3'b011;
            end
            rec_head[hit]  = rec_head[hit] + 4'd1;
            rec_count[hit] = rec_count[hit] - 5'd1;
        end
        rec_expiry[hit] = now_reg + window_reg;
        return 3'b000;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random back-pressure, with stall-free stretches.
    int stall_left;
    int calm_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready = 1'b0;
            stall_left    = 0;
            calm_left     = 0;
        end else if (calm_left > 0) begin
            calm_left     = calm_left - 1;
            m_axis_tready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left    = stall_left - 1;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
            if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(50, 300);
            else stall_left = gap_len();
        end
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (i_cfg_valid && o_cfg_ready)
                || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                if (pend_wr == pend_rd) begin
                    $display("%0t: result transfer with nothing expected, got %b",
                             $time, m_axis_tdata[2:0]);
                    error_count <= error_count + 1;
                end else begin
                    logic [2:0] want;
                    want = pending_verdicts[pend_rd];
                    pend_rd <= pend_rd + 1;
                    verdicts_seen <= verdicts_seen + 1;
                    if (want[1]) new_bans_seen <= new_bans_seen + 1;
                    if (want[2]) full_seen <= full_seen + 1;
                    if (m_axis_tdata !== {5'd0, want}) begin
                        $display("%0t: result mismatch, expected tdata=%h, got tdata=%h",
                                 $time, {5'd0, want}, m_axis_tdata);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Sends one request and records its expected verdict at acceptance.
    task automatic send_request(logic [1:0] req, logic [63:0] addr, logic v6, logic ok,
                                bit typed, logic [2:0] typed_verdict);
        logic [2:0] model_verdict;
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {6'd0, ok, v6, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        model_verdict = ban_verdict(req, addr, v6, ok);
        pending_verdicts[pend_wr] = typed ? typed_verdict : model_verdict;
        pend_wr = pend_wr + 1;
        @(negedge i_clk);
        for (int g = gap_len(); g > 0; g--) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 72'({$urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b0;
    endtask

    // Waits for the block to drain, then writes one register.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        wait (pend_wr == pend_rd);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAX_FAILURES: lim_reg     = value[4:0];
            CFG_WINDOW_TICKS: window_reg  = value;
            CFG_BAN_TICKS:    ban_len_reg = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    typedef struct {
        bit          cfg;
        logic [1:0]  req;
        logic [63:0] addr;
        logic        v6;
        logic        ok;
        bit          typed;
        logic [2:0]  verdict;
    } t_dir_row;

    t_dir_row    dir_rows[DIR_DEPTH];
    int          n_dir = 0;
    logic [63:0] addr_pool[16];

    function automatic t_dir_row mk(logic [1:0] req, logic [63:0] addr, logic v6,
                                    logic ok, bit typed, logic [2:0] verdict);
        t_dir_row r;
        r.cfg = 1'b0; r.req = req; r.addr = addr; r.v6 = v6; r.ok = ok;
        r.typed = typed; r.verdict = verdict;
        return r;
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(t_dir_row r);
        dir_rows[n_dir] = r;
        n_dir = n_dir + 1;
    endtask

    // Random phase: mostly repeat offenders from a small pool, some new addresses.
    task automatic random_phase(int n_items, int fresh_pct, int tick_pct);
        logic [1:0]  req;
        logic [63:0] addr;
        int          r;
        for (int k = 0; k < 16; k++) addr_pool[k] = {$urandom, $urandom};
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < tick_pct) req = REQ_TICK;
            else if (r < tick_pct + 2) req = REQ_UNUSED;
            else if (r < tick_pct + 30) req = REQ_QUERY;
            else req = REQ_FAILURE;
            addr = ($urandom_range(0, 99) < fresh_pct) ? {$urandom, $urandom}
                                                        : addr_pool[$urandom_range(0, 15)];
            send_request(req, addr, 1'($urandom_range(0, 1)), $urandom_range(0, 19) != 0,
                         1'b0, 3'b000);
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        lim_reg       = 5'd0;
        window_reg    = 32'd100;
        ban_len_reg   = 32'd1000;
        now_reg       = 32'd0;
        for (int i = 0; i < SLOTS; i++) begin
            rec_used[i] = 1'b0; rec_key[i] = '0; rec_v6[i] = 1'b0; rec_count[i] = '0;
            rec_head[i] = '0; rec_expiry[i] = '0;
            for (int j = 0; j < STAMP_DEPTH; j++) rec_stamp[i][j] = '0;
        end
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: banning disabled after reset, then a limit of two.
        add_row(mk(REQ_QUERY,   64'h0000_0000_0A00_0001, 1'b0, 1'b1, 1, 3'b000));
        add_row(mk(REQ_FAILURE, 64'h0000_0000_0A00_0001, 1'b0, 1'b1, 1, 3'b000));
        add_row(mk(REQ_FAILURE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1, 3'b000));
        add_row(mk(REQ_TICK,    64'h0,                   1'b0, 1'b1, 1, 3'b000));
        add_row(mk(REQ_UNUSED,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1, 3'b000));
        begin
            t_dir_row c;
            c = mk(REQ_QUERY, 64'h0, 1'b0, 1'b0, 0, 3'b000);
            c.cfg = 1'b1;
            add_row(c);
        end
        add_row(mk(REQ_QUERY,   64'h0,                   1'b0, 1'b0, 1, 3'b001));
        add_row(mk(REQ_FAILURE, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0, 1, 3'b001));
        add_row(mk(REQ_FAILURE, 64'h0000_0000_C0A8_0001, 1'b0, 1'b1, 1, 3'b000));
        add_row(mk(REQ_TICK,    64'h0,                   1'b0, 1'b1, 0, 3'b000));
        add_row(mk(REQ_FAILURE, 64'hDEAD_BEEF_C0A8_0001, 1'b0, 1'b1, 1, 3'b011));
        add_row(mk(REQ_QUERY,   64'h0000_0000_C0A8_0001, 1'b0, 1'b1, 1, 3'b001));
        add_row(mk(REQ_QUERY,   64'h0000_0000_C0A8_0001, 1'b1, 1'b1, 1, 3'b000));
        add_row(mk(REQ_FAILURE, 64'h0000_0000_C0A8_0001, 1'b0, 1'b1, 1, 3'b001));
        add_row(mk(REQ_FAILURE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 0, 3'b000));
        add_row(mk(REQ_FAILURE, 64'h0,                   1'b0, 1'b1, 0, 3'b000));
        add_row(mk(REQ_FAILURE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 0, 3'b000));
        add_row(mk(REQ_QUERY,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 0, 3'b000));
        add_row(mk(REQ_UNUSED,  64'h0,                   1'b0, 1'b1, 1, 3'b000));
        for (int t = 0; t < 4; t++)
            add_row(mk(REQ_TICK, 64'h0, 1'b0, 1'b1, 0, 3'b000));
        add_row(mk(REQ_QUERY,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 0, 3'b000));

        for (int i = 0; i < n_dir; i++) begin
            if (dir_rows[i].cfg) begin
                write_reg(CFG_MAX_FAILURES, 32'd2);
                write_reg(CFG_WINDOW_TICKS, 32'd3);
                write_reg(CFG_BAN_TICKS, 32'd2);
            end else begin
                send_request(dir_rows[i].req, dir_rows[i].addr, dir_rows[i].v6,
                             dir_rows[i].ok, dir_rows[i].typed, dir_rows[i].verdict);
            end
        end

        // Random phases across several settings, extremes included.
        write_reg(CFG_MAX_FAILURES, 32'd3);
        write_reg(CFG_WINDOW_TICKS, 32'd8);
        write_reg(CFG_BAN_TICKS, 32'd20);
        random_phase(260, 10, 20);

        write_reg(CFG_MAX_FAILURES, 32'd1);
        write_reg(CFG_WINDOW_TICKS, 32'd0);
        write_reg(CFG_BAN_TICKS, 32'd0);
        random_phase(200, 20, 30);

        // A huge window and ban with many new addresses fills the table.
        write_reg(CFG_MAX_FAILURES, 32'hFFFF_FFFF);
        write_reg(CFG_WINDOW_TICKS, 32'hFFFF_FFFF);
        write_reg(CFG_BAN_TICKS, 32'hFFFF_FFFF);
        random_phase(300, 45, 3);

        write_reg(CFG_MAX_FAILURES, 32'd16);
        write_reg(CFG_WINDOW_TICKS, 32'd40);
        write_reg(CFG_BAN_TICKS, 32'd100);
        random_phase(320, 5, 6);

        write_reg(CFG_MAX_FAILURES, 32'd5);
        write_reg(CFG_WINDOW_TICKS, 32'd3);
        write_reg(CFG_BAN_TICKS, 32'd10);
        random_phase(220, 10, 25);

        write_reg(CFG_MAX_FAILURES, 32'd0);
        random_phase(60, 20, 10);

        // Drain the remaining results.
        wait (pend_wr == pend_rd);
        repeat (SETTLE) @(negedge i_clk);
        $display("Covered %0d results, %0d new bans and %0d full-table drops",
                 verdicts_seen, new_bans_seen, full_seen);
        $display("over six limit/window/ban settings including the extremes.");
        if (error_count == 0 && pend_wr == pend_rd) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
